>>> rtl/mfde_pkg.sv
// Package for the monochrome frame buffer draw engine.
// Holds command codes, controller states, control structs and the 5x7 font ROM.
// Depends on nothing.
`default_nettype none
package mfde_pkg;

	localparam int FrameWidth  = 128;
	localparam int FrameHeight = 64;
	localparam int StoreBytes  = FrameWidth / 8 * FrameHeight;
	localparam int AddrW       = $clog2(StoreBytes);

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_SET     = 3'd1;
	localparam logic [2:0] CMD_FILL    = 3'd2;
	localparam logic [2:0] CMD_OUTLINE = 3'd3;
	localparam logic [2:0] CMD_CHAR    = 3'd4;
	localparam logic [2:0] CMD_EMIT    = 3'd5;

	localparam logic [7:0] SYNC_CMD  = 8'hF8;
	localparam logic [7:0] SYNC_DATA = 8'hFA;
	localparam logic [7:0] ADDR_BASE = 8'h80;
	localparam logic [7:0] ADDR_LOW  = 8'h88;

	localparam logic [4:0] EMIT_LAST_GROUP = 5'd17;
	localparam logic [1:0] PHASE_SYNC      = 2'd0;
	localparam logic [1:0] PHASE_HI        = 2'd1;
	localparam logic [1:0] PHASE_LO        = 2'd2;

	localparam logic [2:0] ADDR_FLIP = 3'd0;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PRD,
		ST_PWR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic plot_rd;
		logic plot_wr;
		logic emit_step;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic rect_empty;
		logic rect_last;
		logic emit_last;
	} dp_stat_t;

	// Five column bytes, the leftmost column in the top byte; bit 0 is the top row.
	function automatic logic [39:0] glyph_rom(input logic [7:0] code);
		logic [7:0] ch;
		logic [39:0] g;
		ch = code;
		if (code >= 8'h61 && code <= 8'h7A) begin
			ch = code - 8'h20;
		end
		unique case (ch)
			8'h30: g = 40'h3E_51_49_45_3E;
			8'h31: g = 40'h00_42_7F_40_00;
			8'h32: g = 40'h42_61_51_49_46;
			8'h33: g = 40'h21_41_45_4B_31;
			8'h34: g = 40'h18_14_12_7F_10;
			8'h35: g = 40'h27_45_45_45_39;
			8'h36: g = 40'h3C_4A_49_49_30;
			8'h37: g = 40'h01_71_09_05_03;
			8'h38: g = 40'h36_49_49_49_36;
			8'h39: g = 40'h06_49_49_29_1E;
			8'h41: g = 40'h7E_11_11_11_7E;
			8'h42: g = 40'h7F_49_49_49_36;
			8'h43: g = 40'h3E_41_41_41_22;
			8'h44: g = 40'h7F_41_41_22_1C;
			8'h45: g = 40'h7F_49_49_49_41;
			8'h46: g = 40'h7F_09_09_09_01;
			8'h47: g = 40'h3E_41_49_49_7A;
			8'h48: g = 40'h7F_08_08_08_7F;
			8'h49: g = 40'h00_41_7F_41_00;
			8'h4A: g = 40'h20_40_41_3F_01;
			8'h4B: g = 40'h7F_08_14_22_41;
			8'h4C: g = 40'h7F_40_40_40_40;
			8'h4D: g = 40'h7F_02_0C_02_7F;
			8'h4E: g = 40'h7F_04_08_10_7F;
			8'h4F: g = 40'h3E_41_41_41_3E;
			8'h50: g = 40'h7F_09_09_09_06;
			8'h51: g = 40'h3E_41_51_21_5E;
			8'h52: g = 40'h7F_09_19_29_46;
			8'h53: g = 40'h46_49_49_49_31;
			8'h54: g = 40'h01_01_7F_01_01;
			8'h55: g = 40'h3F_40_40_40_3F;
			8'h56: g = 40'h1F_20_40_20_1F;
			8'h57: g = 40'h7F_20_18_20_7F;
			8'h58: g = 40'h63_14_08_14_63;
			8'h59: g = 40'h03_04_78_04_03;
			8'h5A: g = 40'h61_51_49_45_43;
			8'h3A: g = 40'h00_36_36_00_00;
			8'h2E: g = 40'h00_60_60_00_00;
			8'h2D: g = 40'h08_08_08_08_08;
			8'h3E: g = 40'h41_22_14_08_00;
			8'h2F: g = 40'h20_10_08_04_02;
			8'h25: g = 40'h63_13_08_64_63;
			8'h28: g = 40'h00_3E_41_00_00;
			8'h29: g = 40'h00_00_41_3E_00;
			8'h5E: g = 40'h04_02_01_02_04;
			default: g = 40'h0;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] c);
		logic [7:0] col;
		unique case (c)
			3'd0: col = g[39:32];
			3'd1: col = g[31:24];
			3'd2: col = g[23:16];
			3'd3: col = g[15:8];
			3'd4: col = g[7:0];
			default: col = 8'h0;
		endcase
		return col;
	endfunction

endpackage
`default_nettype wire

>>> rtl/mfde_ctrl.sv
// Controller state machine of the draw engine.
// Sequences clearing sweeps, pixel read-modify-write steps and row emission.
// Depends on mfde_pkg.
`default_nettype none
module mfde_ctrl
	import mfde_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] command,
	input  wire dp_stat_t   stat,
	output dp_cmd_t         ctl,
	output logic            busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_SWEEP: begin
				ctl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					unique case (command)
						CMD_CLEAR: state_d = ST_SWEEP;
						CMD_SET, CMD_FILL, CMD_OUTLINE, CMD_CHAR: state_d = ST_PRD;
						CMD_EMIT: state_d = ST_EMIT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PRD: begin
				if (stat.rect_empty) begin
					state_d = ST_IDLE;
				end else begin
					ctl.plot_rd = 1'b1;
					state_d = ST_PWR;
				end
			end
			ST_PWR: begin
				ctl.plot_wr = 1'b1;
				state_d = stat.rect_last ? ST_IDLE : ST_PRD;
			end
			ST_EMIT: begin
				ctl.emit_step = 1'b1;
				if (stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/mfde_dp.sv
// Datapath of the draw engine: frame memory, pixel walker, glyph lookup and serialiser.
// Driven by the controller through dp_cmd_t and reporting through dp_stat_t.
// Depends on mfde_pkg.
`default_nettype none
module mfde_dp
	import mfde_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    ctl,
	input  wire logic       flip,
	input  wire logic [2:0] command,
	input  wire logic [7:0] x,
	input  wire logic [7:0] y,
	input  wire logic [7:0] width,
	input  wire logic [7:0] height,
	input  wire logic       draw,
	input  wire logic [7:0] character,
	input  wire logic [5:0] row,
	output dp_stat_t        stat,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic            last
);

	logic [7:0] mem [StoreBytes];
	logic [7:0] rdata_q;

	logic [2:0] cmd_q;
	logic [7:0] x_q, y_q, w_q, h_q, ch_q;
	logic       on_q;
	logic [5:0] row_q;
	logic [7:0] i_q, j_q;
	logic [AddrW-1:0] sweep_q;
	logic [AddrW-1:0] addr_q;
	logic [7:0] mask_q;
	logic       en_q;
	logic [1:0] phase_q;
	logic [4:0] group_q;
	logic       out_valid_q, last_q;
	logic [7:0] out_byte_q;

	logic [7:0] px, py, wm1, hm1, col, val, byte_d, wdata;
	logic [6:0] xi;
	logic [5:0] yi;
	logic [AddrW-1:0] pix_addr, raddr, waddr;
	logic [4:0] grp_m2;
	logic       pix_en, row_end, interior, we, re;

	assign px = x_q + j_q;
	assign py = y_q + i_q;
	assign xi = flip ? ~px[6:0] : px[6:0];
	assign yi = flip ? ~py[5:0] : py[5:0];
	assign pix_addr = {yi, xi[6:3]};
	assign col = glyph_col(glyph_rom(ch_q), j_q[2:0]);
	assign pix_en = !px[7] && (py[7:6] == 2'b00) && ((cmd_q != CMD_CHAR) || col[i_q[2:0]]);
	assign wm1 = w_q - 8'd1;
	assign hm1 = h_q - 8'd1;
	assign row_end = (j_q == wm1);
	assign interior = (cmd_q == CMD_OUTLINE) && (i_q != 8'd0) && (i_q != hm1);

	assign stat.sweep_last = (sweep_q == AddrW'(StoreBytes - 1));
	assign stat.rect_empty = (w_q == 8'd0) || (h_q == 8'd0);
	assign stat.rect_last  = row_end && (i_q == hm1);
	assign stat.emit_last  = (group_q == EMIT_LAST_GROUP) && (phase_q == PHASE_LO);

	assign grp_m2 = group_q - 5'd2;
	assign we = ctl.sweep || (ctl.plot_wr && en_q);
	assign re = ctl.plot_rd || (ctl.emit_step && (phase_q == PHASE_SYNC));
	assign waddr = ctl.sweep ? sweep_q : addr_q;
	assign raddr = ctl.plot_rd ? pix_addr : {row_q, grp_m2[3:0]};
	assign wdata = ctl.sweep ? 8'h00 : (on_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			x_q   <= x;
			y_q   <= y;
			ch_q  <= character;
			row_q <= row;
			on_q  <= (command == CMD_CHAR) ? 1'b1 : draw;
			w_q   <= (command == CMD_SET) ? 8'd1 : (command == CMD_CHAR) ? 8'd5 : width;
			h_q   <= (command == CMD_SET) ? 8'd1 : (command == CMD_CHAR) ? 8'd7 : height;
		end
		if (ctl.plot_rd) begin
			addr_q <= pix_addr;
			mask_q <= 8'h80 >> xi[2:0];
			en_q   <= pix_en;
		end
		out_byte_q <= byte_d;
	end

	always_comb begin
		priority if (group_q == 5'd0) begin
			val = ADDR_BASE | {3'b000, row_q[4:0]};
		end else if (group_q == 5'd1) begin
			val = row_q[5] ? ADDR_LOW : ADDR_BASE;
		end else begin
			val = rdata_q;
		end
		unique case (phase_q)
			PHASE_SYNC: byte_d = (group_q < 5'd2) ? SYNC_CMD : SYNC_DATA;
			PHASE_HI:   byte_d = {val[7:4], 4'h0};
			default:    byte_d = {val[3:0], 4'h0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			phase_q     <= PHASE_SYNC;
			group_q     <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (ctl.sweep) begin
				sweep_q <= sweep_q + AddrW'(1);
			end
			if (ctl.load) begin
				i_q     <= '0;
				j_q     <= '0;
				phase_q <= PHASE_SYNC;
				group_q <= '0;
			end else if (ctl.plot_wr) begin
				priority if (row_end) begin
					j_q <= '0;
					i_q <= i_q + 8'd1;
				end else if (interior && (j_q == 8'd0)) begin
					j_q <= wm1;
				end else begin
					j_q <= j_q + 8'd1;
				end
			end else if (ctl.emit_step) begin
				if (phase_q == PHASE_LO) begin
					phase_q <= PHASE_SYNC;
					group_q <= group_q + 5'd1;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
			out_valid_q <= ctl.emit_step;
			last_q      <= ctl.emit_step && stat.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule
`default_nettype wire

>>> rtl/monochrome_framebuffer_draw_engine.sv
// Top level of the monochrome frame buffer draw engine.
// Joins mfde_ctrl and mfde_dp and holds the APB configuration register.
// Depends on mfde_pkg, mfde_ctrl and mfde_dp.
//
// A command word is taken when start is high and busy is low. After reset the
// engine clears its 1024-byte frame memory, one byte a cycle, busy until the
// sweep ends; a clear command runs the same sweep. Each pixel position that a
// drawing command visits takes a read and a write of the single frame memory
// (no write off the frame or on a clear glyph bit): set_pixel visits one,
// draw_char 35, fill_rect width*height, outline_rect 2*width + 2*(height-2)
// for widths and heights of two or more; an empty rectangle visits none.
// Emit_row gives 54 bytes back to back, each shown for one cycle with out_valid
// high and last marking the final one; the receiver cannot hold them back.
`default_nettype none
module monochrome_framebuffer_draw_engine
	import mfde_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  x,
	input  wire logic [7:0]  y,
	input  wire logic [7:0]  width,
	input  wire logic [7:0]  height,
	input  wire logic        draw,
	input  wire logic [7:0]  character,
	input  wire logic [5:0]  row,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	dp_cmd_t  ctl;
	dp_stat_t stat;
	logic     flip_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_FLIP) ? {31'b0, flip_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_FLIP)) begin
			flip_q <= pwdata[0];
		end
	end

	mfde_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.ctl     (ctl),
		.busy    (busy)
	);

	mfde_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.flip      (flip_q),
		.command   (command),
		.x         (x),
		.y         (y),
		.width     (width),
		.height    (height),
		.draw      (draw),
		.character (character),
		.row       (row),
		.stat      (stat),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last      (last)
	);

`ifndef SYNTH
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> out_valid) else $error("last without a word");
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(busy)) else $error("word emitted while idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_CLEAR || command == CMD_SET ||
		command == CMD_FILL || command == CMD_OUTLINE || command == CMD_CHAR ||
		command == CMD_EMIT)) |=> busy) else $error("command not taken");
`endif

endmodule
`default_nettype wire
